[src/dbbrc_pkg.sv]
package dbbrc_pkg;

    localparam int NUM_PERIODS = 5;
    localparam int LOG_DEPTH   = 4;
    localparam int LOG_IDX_W   = $clog2(LOG_DEPTH);
    localparam int FILL_W      = $clog2(LOG_DEPTH + 1);
    localparam int SEL_W       = 3;
    localparam int TICK_W      = 8;
    localparam int CFG_IDX_W   = 3;

    typedef logic [SEL_W-1:0]  t_sel;
    typedef logic [TICK_W-1:0] t_tick;

    // register map
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_4 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW   = 3'd6;

    // press log codes
    localparam logic [1:0] PRESS_NONE = 2'd0;
    localparam logic [1:0] PRESS_DOWN = 2'd1;
    localparam logic [1:0] PRESS_UP   = 2'd2;

    localparam t_sel SEL_MAX   = t_sel'(NUM_PERIODS - 1);
    localparam t_sel SEL_RESET = 3'd2;

    localparam t_tick PERIOD_RESET [NUM_PERIODS] = '{8'd20, 8'd40, 8'd60, 8'd80, 8'd100};
    localparam t_tick HOLD_RESET       = 8'd20;
    localparam t_tick WINDOW_RESET     = 8'd100;
    localparam t_tick BLINK_CNT_RESET  = 8'd60;

    typedef struct packed {
        t_tick [NUM_PERIODS-1:0] period;
        t_tick                   hold;
        t_tick                   window;
    } t_cfg;

    typedef struct packed {
        logic red_on;
        logic green_on;
        t_sel red_period_sel;
        t_sel green_period_sel;
        logic green_selected;
    } t_result;

endpackage

[src/dbbrc_core.sv]
module dbbrc_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic             i_down,
    input  logic             i_up,
    input  dbbrc_pkg::t_cfg  i_cfg,
    output dbbrc_pkg::t_result o_next
);
    import dbbrc_pkg::*;

    t_tick r_red_cnt, n_red_cnt, r_green_cnt, n_green_cnt;
    logic  r_red_lvl, n_red_lvl, r_green_lvl, n_green_lvl;
    t_sel  r_red_idx, n_red_idx, r_green_idx, n_green_idx;
    logic  r_down_armed, n_down_armed, r_up_armed, n_up_armed;
    t_tick r_down_cnt, n_down_cnt, r_up_cnt, n_up_cnt;
    logic [LOG_DEPTH-1:0][1:0] r_log, n_log;
    logic [FILL_W-1:0] r_fill, n_fill;
    t_tick r_win_cnt, n_win_cnt;
    logic  r_target, n_target;
    t_sel  sel_cur, sel_mid, sel_new;

    function automatic t_tick period_of(input t_cfg cfg, input t_sel idx);
        t_tick p;
        p = cfg.period[NUM_PERIODS-1];
        for (int k = 0; k < NUM_PERIODS - 1; k++) begin
            if (idx == t_sel'(k)) p = cfg.period[k];
        end
        return p;
    endfunction

    always_comb begin
        // down release timer
        sel_cur      = r_target ? r_green_idx : r_red_idx;
        sel_mid      = sel_cur;
        n_down_armed = r_down_armed;
        n_down_cnt   = r_down_cnt;
        if (i_down) begin
            n_down_armed = 1'b1;
            n_down_cnt   = i_cfg.hold;
        end else if (r_down_armed) begin
            if (r_down_cnt == '0) begin
                if (sel_cur != '0) sel_mid = sel_cur - t_sel'(1);
                n_down_armed = 1'b0;
                n_down_cnt   = i_cfg.hold - t_tick'(1);
            end else begin
                n_down_cnt = r_down_cnt - t_tick'(1);
            end
        end

        // up release timer, sees the index the down timer left
        sel_new    = sel_mid;
        n_up_armed = r_up_armed;
        n_up_cnt   = r_up_cnt;
        if (i_up) begin
            n_up_armed = 1'b1;
            n_up_cnt   = i_cfg.hold;
        end else if (r_up_armed) begin
            if (r_up_cnt == '0) begin
                if (sel_mid < SEL_MAX) sel_new = sel_mid + t_sel'(1);
                n_up_armed = 1'b0;
                n_up_cnt   = i_cfg.hold - t_tick'(1);
            end else begin
                n_up_cnt = r_up_cnt - t_tick'(1);
            end
        end

        n_red_idx   = r_target ? r_red_idx : sel_new;
        n_green_idx = r_target ? sel_new   : r_green_idx;

        // blinkers
        n_red_lvl = r_red_lvl;
        n_red_cnt = r_red_cnt - t_tick'(1);
        if (r_red_cnt == '0) begin
            n_red_lvl = ~r_red_lvl;
            n_red_cnt = period_of(i_cfg, n_red_idx);
        end
        n_green_lvl = r_green_lvl;
        n_green_cnt = r_green_cnt - t_tick'(1);
        if (r_green_cnt == '0) begin
            n_green_lvl = ~r_green_lvl;
            n_green_cnt = period_of(i_cfg, n_green_idx);
        end

        // press window
        n_log     = r_log;
        n_fill    = r_fill;
        n_target  = r_target;
        n_win_cnt = r_win_cnt;
        if (r_win_cnt != '0) begin
            if (i_down && n_fill < FILL_W'(LOG_DEPTH)) begin
                n_log[n_fill[LOG_IDX_W-1:0]] = PRESS_DOWN;
                n_fill = n_fill + FILL_W'(1);
            end
            if (i_up && n_fill < FILL_W'(LOG_DEPTH)) begin
                n_log[n_fill[LOG_IDX_W-1:0]] = PRESS_UP;
                n_fill = n_fill + FILL_W'(1);
            end
            n_win_cnt = r_win_cnt - t_tick'(1);
        end else begin
            n_target  = (r_log[0] == PRESS_DOWN) && (r_log[1] == PRESS_UP) &&
                        (r_log[2] == PRESS_DOWN) && (r_log[3] == PRESS_UP);
            n_log     = '{default: PRESS_NONE};
            n_fill    = '0;
            n_win_cnt = i_cfg.window;
        end

        o_next.red_on           = n_red_lvl;
        o_next.green_on         = n_green_lvl;
        o_next.red_period_sel   = n_red_idx;
        o_next.green_period_sel = n_green_idx;
        o_next.green_selected   = n_target;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_red_cnt    <= BLINK_CNT_RESET;
            r_green_cnt  <= BLINK_CNT_RESET;
            r_red_lvl    <= 1'b0;
            r_green_lvl  <= 1'b0;
            r_red_idx    <= SEL_RESET;
            r_green_idx  <= SEL_RESET;
            r_down_armed <= 1'b0;
            r_down_cnt   <= HOLD_RESET;
            r_up_armed   <= 1'b0;
            r_up_cnt     <= HOLD_RESET;
            r_log        <= '{default: PRESS_NONE};
            r_fill       <= '0;
            r_win_cnt    <= WINDOW_RESET;
            r_target     <= 1'b0;
        end else if (i_step) begin
            r_red_cnt    <= n_red_cnt;
            r_green_cnt  <= n_green_cnt;
            r_red_lvl    <= n_red_lvl;
            r_green_lvl  <= n_green_lvl;
            r_red_idx    <= n_red_idx;
            r_green_idx  <= n_green_idx;
            r_down_armed <= n_down_armed;
            r_down_cnt   <= n_down_cnt;
            r_up_armed   <= n_up_armed;
            r_up_cnt     <= n_up_cnt;
            r_log        <= n_log;
            r_fill       <= n_fill;
            r_win_cnt    <= n_win_cnt;
            r_target     <= n_target;
        end
    end

endmodule

[src/dual_blinker_button_rate_control_core.sv]
// Dual LED blinker with two-button blink-rate control. Each input transaction
// is one tick carrying the two button levels; each tick yields exactly one
// output transaction with both LED levels, both period indexes and which LED
// the buttons currently steer. Throughput is one tick per clock while the
// result side is ready: the input register feeds the state update in the tick
// core, whose result lands in the output register. The output register holds a
// stalled result while the next tick waits in the input register. Configuration
// (period table, hold and window lengths) is written through a plain write port,
// indexes 0..6, and should only be changed while no tick is in flight.
module dual_blinker_button_rate_control_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // tick input channel
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_button_down,
    input  logic                            i_button_up,
    // result channel
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_red_on,
    output logic                            o_green_on,
    output dbbrc_pkg::t_sel                 o_red_period_sel,
    output dbbrc_pkg::t_sel                 o_green_period_sel,
    output logic                            o_green_selected,
    // configuration write port
    input  logic                            i_cfg_we,
    input  logic [dbbrc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  dbbrc_pkg::t_tick                i_cfg_data
);
    import dbbrc_pkg::*;

    t_cfg    r_cfg;
    logic    r_in_valid;
    logic    r_down, r_up;
    logic    r_out_valid;
    t_result r_out;
    t_result next_res;
    logic    advance;

    // the staged tick moves on when the output slot is free or being drained
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    // config registers; unmapped index is ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_PERIODS; k++) r_cfg.period[k] <= PERIOD_RESET[k];
            r_cfg.hold   <= HOLD_RESET;
            r_cfg.window <= WINDOW_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx) inside
                [CFG_PERIOD_0:CFG_PERIOD_4]: r_cfg.period[i_cfg_idx] <= i_cfg_data;
                CFG_HOLD:                    r_cfg.hold   <= i_cfg_data;
                CFG_WINDOW:                  r_cfg.window <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_down <= i_button_down;
            r_up   <= i_button_up;
        end
    end

    // tick state machine: all per-tick work happens here
    dbbrc_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_down  (r_down),
        .i_up    (r_up),
        .i_cfg   (r_cfg),
        .o_next  (next_res)
    );

    // output stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) r_out <= next_res;
    end

    assign o_out_valid        = r_out_valid;
    assign o_red_on           = r_out.red_on;
    assign o_green_on         = r_out.green_on;
    assign o_red_period_sel   = r_out.red_period_sel;
    assign o_green_period_sel = r_out.green_period_sel;
    assign o_green_selected   = r_out.green_selected;

endmodule

[tb/tb_dual_blinker_button_rate_control_core.sv]
`timescale 1ns / 100ps

module tb_dual_blinker_button_rate_control_core;

    import dbbrc_pkg::*;

    // LED and button slots in the local state arrays
    localparam int RED      = 0;
    localparam int GREEN    = 1;
    localparam int BTN_DOWN = 0;
    localparam int BTN_UP   = 1;

    // cycles with no transaction on either channel before the run is declared hung
    localparam int QUIET_LIMIT = 2000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic                 i_button_down;
    logic                 i_button_up;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic                 o_red_on;
    logic                 o_green_on;
    t_sel                 o_red_period_sel;
    t_sel                 o_green_period_sel;
    logic                 o_green_selected;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    t_tick                i_cfg_data;

    dual_blinker_button_rate_control_core dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_button_down      (i_button_down),
        .i_button_up        (i_button_up),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_red_on           (o_red_on),
        .o_green_on         (o_green_on),
        .o_red_period_sel   (o_red_period_sel),
        .o_green_period_sel (o_green_period_sel),
        .o_green_selected   (o_green_selected),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Blinker model: own copy of registers and per-tick state
    // ------------------------------------------------------------------
    t_tick      model_period [NUM_PERIODS];
    t_tick      model_hold;
    t_tick      model_window;
    t_tick      blink_cnt [2];      // indexed RED / GREEN
    logic       led_level [2];
    t_sel       led_sel   [2];
    logic       rel_armed [2];      // indexed BTN_DOWN / BTN_UP
    t_tick      rel_cnt   [2];
    logic [1:0] press_rec [LOG_DEPTH];
    int         rec_fill;
    t_tick      win_cnt;
    logic       steer_green;

    t_result    led_expect_q [$];   // expected result transactions, oldest first
    int         err_count;
    int         ticks_sent;
    bit         tx_idle_en;
    bit         rx_idle_en;
    int         ready_hold_len;     // nonzero asks the result side for one long hold-off

    function automatic void model_reset();
        for (int i = 0; i < NUM_PERIODS; i++) model_period[i] = PERIOD_RESET[i];
        model_hold   = HOLD_RESET;
        model_window = WINDOW_RESET;
        for (int l = 0; l < 2; l++) begin
            blink_cnt[l] = BLINK_CNT_RESET;
            led_level[l] = 1'b0;
            led_sel[l]   = SEL_RESET;
            rel_armed[l] = 1'b0;
            rel_cnt[l]   = HOLD_RESET;
        end
        for (int i = 0; i < LOG_DEPTH; i++) press_rec[i] = PRESS_NONE;
        rec_fill    = 0;
        win_cnt     = WINDOW_RESET;
        steer_green = 1'b0;
    endfunction

    // Advance one tick and return the result transaction it should produce.
    function automatic t_result step_model(input logic dn, input logic up);
        t_result r;
        logic    pressed;
        int      tgt;
        t_sel    idx;
        tgt = steer_green ? GREEN : RED;

        // release timers: down first, then up; the up timer sees the down step
        for (int b = 0; b < 2; b++) begin
            pressed = (b == BTN_DOWN) ? dn : up;
            if (pressed) begin
                rel_armed[b] = 1'b1;
                rel_cnt[b]   = model_hold;
            end else if (rel_armed[b]) begin
                if (rel_cnt[b] == 0) begin
                    // at a limit the timer just disarms
                    if (b == BTN_DOWN) begin
                        if (led_sel[tgt] > 0) led_sel[tgt] = led_sel[tgt] - 1'b1;
                    end else if (led_sel[tgt] < SEL_MAX) begin
                        led_sel[tgt] = led_sel[tgt] + 1'b1;
                    end
                    rel_armed[b] = 1'b0;
                    rel_cnt[b]   = model_hold;
                end
                rel_cnt[b] = rel_cnt[b] - 1'b1;   // wraps at 8 bits
            end
        end

        // blinkers: red then green, reload uses the index just updated
        for (int l = 0; l < 2; l++) begin
            if (blink_cnt[l] != 0) begin
                blink_cnt[l] = blink_cnt[l] - 1'b1;
            end else begin
                led_level[l] = ~led_level[l];
                idx          = (led_sel[l] < NUM_PERIODS) ? led_sel[l] : SEL_MAX;
                blink_cnt[l] = model_period[idx];
            end
        end

        // press window: log up to LOG_DEPTH presses, down before up
        if (win_cnt != 0) begin
            if (dn && rec_fill < LOG_DEPTH) begin
                press_rec[rec_fill] = PRESS_DOWN;
                rec_fill++;
            end
            if (up && rec_fill < LOG_DEPTH) begin
                press_rec[rec_fill] = PRESS_UP;
                rec_fill++;
            end
            win_cnt = win_cnt - 1'b1;
        end else begin
            steer_green = (press_rec[0] == PRESS_DOWN) && (press_rec[1] == PRESS_UP) &&
                          (press_rec[2] == PRESS_DOWN) && (press_rec[3] == PRESS_UP);
            for (int i = 0; i < LOG_DEPTH; i++) press_rec[i] = PRESS_NONE;
            rec_fill = 0;
            win_cnt  = model_window;
        end

        r.red_on           = led_level[RED];
        r.green_on         = led_level[GREEN];
        r.red_period_sel   = led_sel[RED];
        r.green_period_sel = led_sel[GREEN];
        r.green_selected   = steer_green;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result side: ready with random hold-off bursts, plus the long stall
    // ------------------------------------------------------------------
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (ready_hold_len > 0) begin
                // long hold-off so the input side backs up and stalls
                i_out_ready <= 1'b0;
                repeat (ready_hold_len) @(negedge i_clk);
                ready_hold_len = 0;
                i_out_ready <= 1'b1;
            end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(0, 11)) @(negedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    function automatic void check_field(input string what, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
            err_count++;
        end
    endfunction

    // every accepted result transaction is matched against the oldest expectation
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (led_expect_q.size() == 0) begin
                $display("%0t: result transaction with no tick pending: expected none, actual %b",
                         $time, {o_red_on, o_green_on, o_red_period_sel,
                                 o_green_period_sel, o_green_selected});
                err_count++;
            end else begin
                want = led_expect_q.pop_front();
                check_field("red_on",           want.red_on,           o_red_on);
                check_field("green_on",         want.green_on,         o_green_on);
                check_field("red_period_sel",   want.red_period_sel,   o_red_period_sel);
                check_field("green_period_sel", want.green_period_sel, o_green_period_sel);
                check_field("green_selected",   want.green_selected,   o_green_selected);
            end
        end
    end

    // hang detector: counts cycles in which neither channel moves a transaction
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
            $display("dual_blinker_button_rate_control_core verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers; all of them start and end on a falling edge
    // ------------------------------------------------------------------

    // Offer one tick, wait for acceptance, record its expected result.
    task automatic send_tick(input logic dn, input logic up);
        i_in_valid    <= 1'b1;
        i_button_down <= dn;
        i_button_up   <= up;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        led_expect_q.push_back(step_model(dn, up));
        ticks_sent++;
        @(negedge i_clk);
        // valid stays up when the next tick follows at once
        if (tx_idle_en && $urandom_range(0, 7) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
    endtask

    // Stop offering and wait until every expected result has come back.
    task automatic wait_results_done();
        i_in_valid <= 1'b0;
        while (led_expect_q.size() != 0) @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Write all seven registers; periods[0] is period_0.
    task automatic write_config(input t_tick [NUM_PERIODS-1:0] periods,
                                input t_tick hold, input t_tick window);
        i_cfg_we <= 1'b1;
        for (int i = 0; i < NUM_PERIODS; i++) begin
            i_cfg_idx  <= CFG_PERIOD_0 + i[CFG_IDX_W-1:0];
            i_cfg_data <= periods[i];
            @(negedge i_clk);
            model_period[i] = periods[i];
        end
        i_cfg_idx  <= CFG_HOLD;
        i_cfg_data <= hold;
        @(negedge i_clk);
        model_hold = hold;
        i_cfg_idx  <= CFG_WINDOW;
        i_cfg_data <= window;
        @(negedge i_clk);
        model_window = window;
        i_cfg_we <= 1'b0;
    endtask

    task automatic write_small_config();
        t_tick [NUM_PERIODS-1:0] p;
        for (int i = 0; i < NUM_PERIODS; i++) p[i] = $urandom_range(0, 6);
        write_config(p, $urandom_range(0, 4), $urandom_range(4, 20));
    endtask

    // Wait until the press log is empty, then enter down,up,down,up -- the pattern
    // that hands the buttons to green. Some attempts are deliberately broken.
    task automatic unlock_attempt();
        logic [1:0] pat [4];   // bit 0 = down button, bit 1 = up button
        pat = '{PRESS_DOWN, PRESS_UP, PRESS_DOWN, PRESS_UP};
        while (rec_fill != 0) send_tick(1'b0, 1'b0);
        if ($urandom_range(0, 3) == 0) pat[$urandom_range(0, 3)] = $urandom_range(0, 3);
        for (int i = 0; i < 4; i++) begin
            send_tick(pat[i][0], pat[i][1]);
            repeat ($urandom_range(0, 2)) send_tick(1'b0, 1'b0);
        end
    endtask

    // Mixed random traffic: unlock sequences, taps with enough release time to
    // step the index, held buttons, noise and quiet stretches.
    task automatic run_ticks(input int n);
        int         stop_at;
        int         kind;
        logic [1:0] b;
        stop_at = ticks_sent + n;
        while (ticks_sent < stop_at) begin
            kind = $urandom_range(0, 9);
            b    = $urandom_range(1, 3);
            if (kind < 4) begin
                unlock_attempt();
            end else if (kind < 7) begin
                send_tick(b[0], b[1]);
                repeat ($urandom_range(0, model_hold + 2)) send_tick(1'b0, 1'b0);
            end else if (kind == 7) begin
                repeat ($urandom_range(2, 6)) send_tick(b[0], b[1]);
            end else if (kind == 8) begin
                repeat ($urandom_range(1, 8)) send_tick($urandom_range(0, 1),
                                                        $urandom_range(0, 1));
            end else begin
                repeat ($urandom_range(1, 8)) send_tick(1'b0, 1'b0);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Hold of zero makes a tap step on the very next idle tick, so the red
    // index walks to both limits in a few ticks; zero and 255 periods reload.
    task automatic test_directed();
        write_config({8'd255, 8'd3, 8'd2, 8'd1, 8'd0}, 8'd0, 8'd3);
        send_tick(1'b0, 1'b0);
        repeat (3) begin                      // 2 -> 1 -> 0, then held at zero
            send_tick(1'b1, 1'b0);
            send_tick(1'b0, 1'b0);
        end
        send_tick(1'b1, 1'b1);                // both on one tick, down logged first
        send_tick(1'b0, 1'b0);
        repeat (4) begin                      // up to the top, then held at four
            send_tick(1'b0, 1'b1);
            send_tick(1'b0, 1'b0);
        end
        repeat (3) send_tick(1'b0, 1'b1);     // button held across ticks
        send_tick(1'b0, 1'b0);
    endtask

    // Result side holds off for a long stretch while ticks keep coming.
    task automatic test_input_stall();
        wait_results_done();
        tx_idle_en     = 1'b0;
        ready_hold_len = 80;
        repeat (24) send_tick($urandom_range(0, 1), $urandom_range(0, 1));
        tx_idle_en = 1'b1;
    endtask

    task automatic test_random_small(input int n);
        wait_results_done();
        write_small_config();
        run_ticks(n);
    endtask

    task automatic test_high_extremes();
        wait_results_done();
        write_config({NUM_PERIODS{8'd255}}, 8'd255, 8'd255);
        run_ticks(150);
    endtask

    // zero window: every tick re-evaluates the pattern and logs nothing
    task automatic test_zero_extremes();
        wait_results_done();
        write_config({NUM_PERIODS{8'd0}}, 8'd0, 8'd0);
        run_ticks(150);
    endtask

    task automatic test_reset_values();
        wait_results_done();
        write_config({8'd100, 8'd80, 8'd60, 8'd40, 8'd20}, 8'd20, 8'd100);
        run_ticks(300);
    endtask

    // last stretch runs back to back on both sides
    task automatic test_no_idle();
        wait_results_done();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        write_small_config();
        run_ticks(300);
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_button_down  = 1'b0;
        i_button_up    = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = CFG_PERIOD_0;
        i_cfg_data     = '0;
        err_count      = 0;
        ticks_sent     = 0;
        tx_idle_en     = 1'b1;
        rx_idle_en     = 1'b1;
        ready_hold_len = 0;
        model_reset();
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        test_input_stall();
        test_random_small(600);
        test_high_extremes();
        test_zero_extremes();
        test_reset_values();
        test_random_small(400);
        test_no_idle();

        wait_results_done();
        repeat (8) @(posedge i_clk);
        if (err_count == 0 && led_expect_q.size() == 0) begin
            $display("dual_blinker_button_rate_control_core verification clean");
        end else begin
            $display("dual_blinker_button_rate_control_core verification failed");
        end
        $finish;
    end

endmodule
